// ===== src/swre_pkg.sv =====
// shared types and constants of the sensor window rule engine
package swre_pkg;

    localparam int VALUE_W      = 32;
    localparam int SENSOR_W     = 8;
    localparam int RULE_ID_W    = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int RULE_INDEX_W = 5;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_LOWEST  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_HIGHEST = 1'b1;

    // input actions
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_READING = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_STORED   = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;
    localparam logic [1:0] KIND_FULL     = 2'd3;

    // rule levels
    localparam logic [1:0] LEVEL_LOW    = 2'd0;
    localparam logic [1:0] LEVEL_NORMAL = 2'd1;
    localparam logic [1:0] LEVEL_HIGH   = 2'd2;

    localparam logic [2:0] LIST_NONE        = 3'd0;
    localparam logic [2:0] LIST_ENTER_BASE  = 3'd3;

    typedef struct packed {
        logic [2:0] exit_lists;
        logic [2:0] enter_lists;
    } command_mask_t;

    typedef struct packed {
        logic [1:0]                  action;
        logic [SENSOR_W-1:0]         sensor_id;
        logic signed [VALUE_W-1:0]   reading_value;
        logic signed [VALUE_W-1:0]   low_limit;
        logic signed [VALUE_W-1:0]   high_limit;
        logic [RULE_ID_W-1:0]        rule_id;
        logic                        has_name;
        logic [5:0]                  command_mask;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic [RULE_INDEX_W-1:0] rule_index;
        logic [2:0]              command_list;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic [SENSOR_W-1:0]       sensor;
        logic signed [VALUE_W-1:0] low;
        logic signed [VALUE_W-1:0] high;
        command_mask_t             commands;
        logic [1:0]                level;
    } rule_entry_t;

endpackage

// ===== src/swre_rule_mem.sv =====
// rule table memory, one write and one registered read port
module swre_rule_mem #(
    parameter int RULE_SLOTS = 32,
    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  swre_pkg::rule_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output swre_pkg::rule_entry_t rd_data
);
    import swre_pkg::*;

    rule_entry_t mem [RULE_SLOTS];
    rule_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/swre_seq.sv =====
// sequencer: rule loading, table walk per reading, result buffering
module swre_seq #(
    parameter int RULE_SLOTS = 32,
    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
    localparam int CNT_W = $clog2(RULE_SLOTS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  swre_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output swre_pkg::out_item_t                 out_item,
    input  logic [swre_pkg::RULE_ID_W-1:0]      id_lowest,
    input  logic [swre_pkg::RULE_ID_W-1:0]      id_highest,
    output logic                                mem_wr_en,
    output logic [IDX_W-1:0]                    mem_wr_addr,
    output swre_pkg::rule_entry_t               mem_wr_data,
    output logic                                mem_rd_en,
    output logic [IDX_W-1:0]                    mem_rd_addr,
    input  swre_pkg::rule_entry_t               mem_rd_data
);
    import swre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       exit_done_reg, exit_done_next;
    logic                       hold_valid_reg, hold_valid_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  hold_reg, hold_next;
    out_item_t                  out_reg, out_next;
    logic [SENSOR_W-1:0]        sensor_reg, sensor_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;

    logic        accept;
    logic        out_free;
    logic        can_push;
    logic        match;
    logic [1:0]  new_lvl;
    logic [1:0]  old_lvl;
    logic        trans;
    logic        exit_pend;
    logic        enter_pend;
    logic        rule_done;
    logic        last_rule;
    logic        push;
    out_item_t   push_item;
    logic        rule_ok;
    logic        table_full;
    rule_entry_t load_entry;
    rule_entry_t walk_entry;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign can_push  = !hold_valid_reg || out_free;

    // classification of the rule held in the read register
    always_comb
    begin
        match = (mem_rd_data.sensor == sensor_reg);
        if (value_reg < mem_rd_data.low)
        begin
            new_lvl = LEVEL_LOW;
        end
        else if (value_reg > mem_rd_data.high)
        begin
            new_lvl = LEVEL_HIGH;
        end
        else
        begin
            new_lvl = LEVEL_NORMAL;
        end
        old_lvl = (mem_rd_data.level > LEVEL_HIGH) ? LEVEL_NORMAL : mem_rd_data.level;
    end

    assign trans      = match && (new_lvl != old_lvl);
    assign exit_pend  = trans && mem_rd_data.commands.exit_lists[old_lvl] && !exit_done_reg;
    assign enter_pend = trans && mem_rd_data.commands.enter_lists[new_lvl];
    assign rule_done  = !exit_pend && (!enter_pend || can_push);
    assign last_rule  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign rule_ok    = (in_item.rule_id >= id_lowest) && (in_item.rule_id <= id_highest)
                        && in_item.has_name
                        && (in_item.command_mask[2:0] != 3'd0);
    assign table_full = (count_reg >= CNT_W'(RULE_SLOTS));

    always_comb
    begin
        load_entry.sensor   = in_item.sensor_id;
        load_entry.low      = in_item.low_limit;
        load_entry.high     = in_item.high_limit;
        load_entry.commands = command_mask_t'(in_item.command_mask);
        load_entry.level    = LEVEL_NORMAL;
        walk_entry          = mem_rd_data;
        walk_entry.level    = new_lvl;
    end

    always_comb
    begin
        push_item.result_kind = KIND_DISPATCH;
        push_item.rule_index  = RULE_INDEX_W'(idx_reg);
        push_item.last        = 1'b0;
        if (exit_pend)
        begin
            push_item.command_list = {1'b0, old_lvl};
        end
        else
        begin
            push_item.command_list = LIST_ENTER_BASE + {1'b0, new_lvl};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        exit_done_next  = exit_done_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        sensor_next     = sensor_reg;
        value_next      = value_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = walk_entry;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        push            = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_LOAD:
                        begin
                            hold_valid_next = 1'b1;
                            hold_next.last         = 1'b0;
                            hold_next.command_list = LIST_NONE;
                            hold_next.rule_index   = '0;
                            state_next = ST_FLUSH;
                            if (!rule_ok)
                            begin
                                hold_next.result_kind = KIND_REJECTED;
                            end
                            else if (table_full)
                            begin
                                hold_next.result_kind = KIND_FULL;
                            end
                            else
                            begin
                                hold_next.result_kind = KIND_STORED;
                                hold_next.rule_index  = RULE_INDEX_W'(count_reg);
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = IDX_W'(count_reg);
                                mem_wr_data = load_entry;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_READING:
                        begin
                            if (count_reg != '0)
                            begin
                                sensor_next    = in_item.sensor_id;
                                value_next     = in_item.reading_value;
                                idx_next       = '0;
                                exit_done_next = 1'b0;
                                mem_rd_en      = 1'b1;
                                mem_rd_addr    = '0;
                                state_next     = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if ((exit_pend || enter_pend) && can_push)
                begin
                    push = 1'b1;
                    if (exit_pend)
                    begin
                        exit_done_next = 1'b1;
                    end
                end
                if (rule_done)
                begin
                    exit_done_next = 1'b0;
                    if (trans)
                    begin
                        mem_wr_en = 1'b1;
                    end
                    if (last_rule)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next    = idx_reg + IDX_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + IDX_W'(1);
                    end
                end
                if (push)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        out_next.last  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_next       = push_item;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            exit_done_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            exit_done_reg  <= exit_done_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        out_reg    <= out_next;
        sensor_reg <= sensor_next;
        value_reg  <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== src/sensor_window_rule_engine_top.sv =====
// top level of the sensor window rule engine: config registers, sequencer, rule memory
//
// Holds up to RULE_SLOTS threshold rules in a single rule memory. A load item gives one
// result (stored, rejected or table full). A reading walks the stored rules in table
// order, one rule per cycle through the rule memory's read port; a rule that emits an
// exit command, or a stalled output, holds the walk. Each item is taken only after the
// previous one has finished; finished results wait in an output register so the next
// item can start. Id range registers must be written while idle.
module sensor_window_rule_engine_top #(
    parameter int RULE_SLOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  swre_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output swre_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [swre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swre_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swre_pkg::*;

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    logic [RULE_ID_W-1:0] id_lowest_reg;
    logic [RULE_ID_W-1:0] id_highest_reg;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    rule_entry_t      mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    rule_entry_t      mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_lowest_reg  <= '0;
            id_highest_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ID_LOWEST:  id_lowest_reg  <= cfg_data;
                CFG_ID_HIGHEST: id_highest_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    swre_seq #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .id_lowest   (id_lowest_reg),
        .id_highest  (id_highest_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    swre_rule_mem #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_rule_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== sim/swre_checker.sv =====
// rule engine checker: tracks rule table, predicts results and compares them
`timescale 1ns / 100ps

module swre_checker #(
    parameter int RULE_SLOTS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  swre_pkg::in_item_t               in_item,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  swre_pkg::out_item_t              out_item,
    input  logic                             cfg_we,
    input  logic [swre_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swre_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               results_owed
);
    import swre_pkg::*;

    logic [SENSOR_W-1:0]       watch_sensor [RULE_SLOTS];
    logic signed [VALUE_W-1:0] floor_limit [RULE_SLOTS];
    logic signed [VALUE_W-1:0] ceiling_limit [RULE_SLOTS];
    logic [5:0]                rule_mask [RULE_SLOTS];
    logic [1:0]                rule_state [RULE_SLOTS];
    int                        rule_total;
    logic [RULE_ID_W-1:0]      id_floor;
    logic [RULE_ID_W-1:0]      id_ceiling;
    out_item_t                 results_due [$];
    out_item_t                 due;

    function automatic out_item_t result_of(logic [1:0] kind, logic [RULE_INDEX_W-1:0] idx,
                                            logic [2:0] list, logic fin);
        out_item_t r;
        r.result_kind  = kind;
        r.rule_index   = idx;
        r.command_list = list;
        r.last         = fin;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic apply_item(input in_item_t it);
        logic      acceptable;
        logic [1:0] was_level;
        logic [1:0] now_level;
        int        emitted;
        out_item_t tail;
        emitted = 0;
        case (it.action)
            ACT_CLEAR:
            begin
                rule_total = 0;
            end
            ACT_LOAD:
            begin
                acceptable = it.rule_id >= id_floor && it.rule_id <= id_ceiling
                             && it.has_name && it.command_mask[2:0] != 3'd0;
                if (!acceptable)
                    results_due.push_back(result_of(KIND_REJECTED, '0, LIST_NONE, 1'b1));
                else if (rule_total >= RULE_SLOTS)
                    results_due.push_back(result_of(KIND_FULL, '0, LIST_NONE, 1'b1));
                else
                begin
                    watch_sensor[rule_total]  = it.sensor_id;
                    floor_limit[rule_total]   = it.low_limit;
                    ceiling_limit[rule_total] = it.high_limit;
                    rule_mask[rule_total]     = it.command_mask;
                    rule_state[rule_total]    = LEVEL_NORMAL;
                    results_due.push_back(result_of(KIND_STORED, RULE_INDEX_W'(rule_total),
                                                    LIST_NONE, 1'b1));
                    rule_total++;
                end
            end
            ACT_READING:
            begin
                for (int i = 0; i < rule_total; i++)
                begin
                    if (watch_sensor[i] == it.sensor_id)
                    begin
                        if (it.reading_value < floor_limit[i])
                            now_level = LEVEL_LOW;
                        else if (it.reading_value > ceiling_limit[i])
                            now_level = LEVEL_HIGH;
                        else
                            now_level = LEVEL_NORMAL;
                        was_level = rule_state[i];
                        if (now_level != was_level)
                        begin
                            if (rule_mask[i][3 + was_level])
                            begin
                                results_due.push_back(result_of(KIND_DISPATCH,
                                    RULE_INDEX_W'(i), {1'b0, was_level}, 1'b0));
                                emitted++;
                            end
                            if (rule_mask[i][now_level])
                            begin
                                results_due.push_back(result_of(KIND_DISPATCH,
                                    RULE_INDEX_W'(i), LIST_ENTER_BASE + now_level, 1'b0));
                                emitted++;
                            end
                            rule_state[i] = now_level;
                        end
                    end
                end
                if (emitted > 0)
                begin
                    tail = results_due.pop_back();
                    tail.last = 1'b1;
                    results_due.push_back(tail);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count   = 0;
            results_owed = 0;
            rule_total   = 0;
            id_floor     = '0;
            id_ceiling   = '1;
            results_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: kind %0d index %0d list %0d last %0d",
                           out_item.result_kind, out_item.rule_index,
                           out_item.command_list, out_item.last);
                    fail_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("result_kind", int'(due.result_kind),
                                int'(out_item.result_kind));
                    check_field("rule_index", int'(due.rule_index),
                                int'(out_item.rule_index));
                    check_field("command_list", int'(due.command_list),
                                int'(out_item.command_list));
                    check_field("last", int'(due.last), int'(out_item.last));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ID_LOWEST:  id_floor = cfg_data;
                    CFG_ID_HIGHEST: id_ceiling = cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
                apply_item(in_item);
            results_owed = results_due.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// rule engine testbench top: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import swre_pkg::*;

    localparam int RULE_SLOTS    = 32;
    localparam int RANDOM_ITEMS  = 130;
    localparam int SETTLE_CYCLES = 48;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     results_owed;

    int                        burst_left = 0;
    int                        items_sent = 0;
    int                        stall_mode = 0;
    int                        mode_left = 0;
    int                        episode;
    logic [RULE_ID_W-1:0]      win_lo;
    logic [RULE_ID_W-1:0]      win_hi;
    logic [RULE_ID_W-1:0]      pick_a;
    logic [RULE_ID_W-1:0]      pick_b;
    logic signed [VALUE_W-1:0] episode_limits [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sensor_window_rule_engine_top #(
        .RULE_SLOTS(RULE_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    swre_checker #(
        .RULE_SLOTS(RULE_SLOTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_owed(results_owed)
    );

    // receiver stall pattern: free running, random, or mostly stalled stretches
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 60);
        end
        mode_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic in_item_t noise_item();
        in_item_t it;
        it.action        = 2'($urandom_range(0, 3));
        it.sensor_id     = 8'($urandom);
        it.reading_value = $urandom;
        it.low_limit     = $urandom;
        it.high_limit    = $urandom;
        it.rule_id       = 16'($urandom);
        it.has_name      = 1'($urandom_range(0, 1));
        it.command_mask  = 6'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_item(logic [1:0] action, logic [SENSOR_W-1:0] sensor,
                                           logic signed [VALUE_W-1:0] value,
                                           logic signed [VALUE_W-1:0] lo,
                                           logic signed [VALUE_W-1:0] hi,
                                           logic [RULE_ID_W-1:0] id, logic named,
                                           logic [5:0] mask);
        in_item_t it;
        it.action        = action;
        it.sensor_id     = sensor;
        it.reading_value = value;
        it.low_limit     = lo;
        it.high_limit    = hi;
        it.rule_id       = id;
        it.has_name      = named;
        it.command_mask  = mask;
        return it;
    endfunction

    function automatic logic [RULE_ID_W-1:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return win_lo;
            1:       return win_hi;
            2:       return win_lo - 16'd1;
            3:       return win_hi + 16'd1;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(win_lo, win_hi));
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3 && episode_limits.size() > 0)
            return episode_limits[$urandom_range(0, episode_limits.size() - 1)]
                   + 32'($urandom_range(0, 2)) - 32'd1;
        else if (sel < 5)
            return 32'($urandom);
        else
            return 32'($urandom_range(0, 200 << 16)) - 32'(100 << 16);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        if (it.action != ACT_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic set_window(input logic [RULE_ID_W-1:0] lo, input logic [RULE_ID_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ID_LOWEST;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_ID_HIGHEST;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_we <= 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    task automatic run_episode(input int ep);
        logic                      fill;
        logic [SENSOR_W-1:0]       home;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        in_item_t                  it;
        int                        loads;
        int                        readings;
        fill = (ep == 1);
        home = 8'($urandom);
        episode_limits.delete();
        if (fill || $urandom_range(0, 3) != 0)
        begin
            it = noise_item();
            it.action = ACT_CLEAR;
            send_item(it);
        end
        loads = fill ? RULE_SLOTS + 4 : $urandom_range(1, 8);
        repeat (loads)
        begin
            it = noise_item();
            it.action = ACT_LOAD;
            if (fill)
            begin
                it.sensor_id    = home;
                it.rule_id      = 16'($urandom_range(win_lo, win_hi));
                it.has_name     = 1'b1;
                it.command_mask = 6'h3F;
                it.low_limit    = -Q_ONE;
                it.high_limit   = Q_ONE;
            end
            else
            begin
                it.sensor_id = home + 8'($urandom_range(0, 2));
                it.rule_id   = pick_id();
                it.has_name  = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 6) != 0)
                    it.command_mask[$urandom_range(0, 2)] = 1'b1;
                if ($urandom_range(0, 9) != 0)
                begin
                    lo = 32'($urandom_range(0, 128 << 16)) - 32'(64 << 16);
                    hi = lo + 32'($urandom_range(0, 32 << 16));
                    it.low_limit  = lo;
                    it.high_limit = hi;
                end
            end
            episode_limits.push_back(it.low_limit);
            episode_limits.push_back(it.high_limit);
            send_item(it);
            // stray items between loads
            if ($urandom_range(0, 9) == 0)
            begin
                it = noise_item();
                it.action = $urandom_range(0, 1) ? ACT_UNUSED : ACT_READING;
                send_item(it);
            end
        end
        readings = fill ? 10 : $urandom_range(3, 14);
        repeat (readings)
        begin
            it = noise_item();
            it.action = ACT_READING;
            if ($urandom_range(0, 7) != 0)
                it.sensor_id = home + (fill ? 8'd0 : 8'($urandom_range(0, 2)));
            if (fill)
            begin
                case ($urandom_range(0, 3))
                    0:       it.reading_value = 2 * Q_ONE;
                    1:       it.reading_value = -2 * Q_ONE;
                    2:       it.reading_value = '0;
                    default: it.reading_value = pick_value();
                endcase
            end
            else
                it.reading_value = pick_value();
            send_item(it);
            if ($urandom_range(0, 24) == 0)
                settle();
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_window(16'd0, 16'hFFFF);

        // directed items
        send_item(make_item(ACT_CLEAR, 8'd0, '0, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_LOAD, 8'd5, '0, -Q_ONE, Q_ONE, 16'd0, 1'b1, 6'h3F));
        send_item(make_item(ACT_LOAD, 8'hFF, '0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            16'hFFFF, 1'b1, 6'h3F));
        send_item(make_item(ACT_LOAD, 8'd7, '0, '0, '0, 16'd1234, 1'b1, 6'h01));
        send_item(make_item(ACT_LOAD, 8'd5, '0, 10 * Q_ONE, 20 * Q_ONE, 16'd7, 1'b1, 6'h24));
        send_item(make_item(ACT_LOAD, 8'd5, '0, '0, '0, 16'd8, 1'b0, 6'h3F));
        send_item(make_item(ACT_LOAD, 8'd5, '0, '0, '0, 16'd9, 1'b1, 6'h38));
        send_item(make_item(ACT_LOAD, 8'd5, '0, '0, '0, 16'd9, 1'b1, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, 2 * Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, 25 * Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, -2 * Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, -Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, -Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'hFF, 32'sh8000_0000, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'hFF, 32'sh7FFF_FFFF, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd7, -32'sd1, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd7, '0, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd7, 32'sd1, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd7, -32'sd1, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd42, '0, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_UNUSED, 8'd5, 2 * Q_ONE, '1, '1, 16'hFFFF, 1'b1, 6'h3F));
        send_item(make_item(ACT_CLEAR, 8'd0, '0, '0, '0, 16'd0, 1'b0, 6'h00));
        send_item(make_item(ACT_READING, 8'd5, 100 * Q_ONE, '0, '0, 16'd0, 1'b0, 6'h00));
        settle();

        episode = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (episode)
                0: set_window(16'd100, 16'd200);
                1: set_window(16'd0, 16'hFFFF);
                2: set_window(16'd300, 16'd299);
                3: set_window(16'hFFFF, 16'hFFFF);
                4: set_window(16'd0, 16'd0);
                default:
                begin
                    pick_a = 16'($urandom);
                    pick_b = 16'($urandom);
                    if ($urandom_range(0, 3) != 0 && pick_a > pick_b)
                        set_window(pick_b, pick_a);
                    else
                        set_window(pick_a, pick_b);
                end
            endcase
            run_episode(episode);
            settle();
            episode++;
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
